/* hdl/fafw_pkg.sv */
// ----------------------------------------------------------------------------
// fafw_pkg
// Shared types, codes and helpers of the fully associative write-through
// cache: access kinds, back-end states, queue entry and control structs.
// ----------------------------------------------------------------------------
package fafw_pkg;

  localparam int unsigned BLK_W       = 5;
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned LINE_OUT_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_LOOKUP,
    ST_UPDATE
  } back_state_e;

  // classified request as it sits in the queue
  typedef struct packed {
    func_e             func;
    logic [BLK_W-1:0]  blk;
    logic [SEL_W-1:0]  sel;
    logic              in_range;
    logic [BYTE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } queue_out_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* hdl/fafw_if.sv */
// ----------------------------------------------------------------------------
// fafw_if
// Valid/ready channels of the cache: request channel and response channel.
// ----------------------------------------------------------------------------
interface fafw_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [4:0] block_address;
  logic [1:0] word_select;
  logic [7:0] write_value;

  modport source (output valid, func, block_address, word_select, write_value,
                  input ready);
  modport sink   (input valid, func, block_address, word_select, write_value,
                  output ready);
endinterface

interface fafw_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  line_index;
  logic        line_mark;
  logic [4:0]  line_tag;
  logic [7:0]  data;
  logic [15:0] read_hits;
  logic [15:0] read_misses;
  logic [15:0] write_hits;
  logic [15:0] write_misses;

  modport source (output valid, hit, line_index, line_mark, line_tag, data,
                  read_hits, read_misses, write_hits, write_misses,
                  input ready);
  modport sink   (input valid, hit, line_index, line_mark, line_tag, data,
                  read_hits, read_misses, write_hits, write_misses,
                  output ready);
endinterface

/* hdl/fully_assoc_cache_fifo_write_through.sv */
// ----------------------------------------------------------------------------
// fully_assoc_cache_fifo_write_through
// Fully associative cache with FIFO replacement, write-allocate and
// write-through, in front of a main memory of MEMORY_BLOCKS blocks. Each
// request transaction returns one response transaction with hit, line index,
// mark, tag, selected byte and saturating read/write hit/miss counters.
// After reset the block loads main memory with its start contents and takes
// no request until then. Each access then passes through the back-end
// sequencer's lookup state (tag compare, main memory read) and its update
// state (line update, write-through, response load; waits while an untaken
// response is held). A two-entry request queue and the response register
// let the request and response sides stall independently.
// ----------------------------------------------------------------------------
module fully_assoc_cache_fifo_write_through #(
  parameter int unsigned CACHE_LINES    = 8,
  parameter int unsigned MEMORY_BLOCKS  = 32,
  parameter int unsigned BYTES_PER_LINE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fafw_in_if.sink     req_i,
  fafw_out_if.source  rsp_o
);

  fafw_pkg::queue_out_t head;
  fafw_pkg::back_ctl_t  ctl;

  fafw_front #(
    .MEMORY_BLOCKS  (MEMORY_BLOCKS),
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .head_o (head)
  );

  fafw_back #(
    .CACHE_LINES    (CACHE_LINES),
    .MEMORY_BLOCKS  (MEMORY_BLOCKS),
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .ctl_o  (ctl),
    .rsp_o  (rsp_o)
  );

endmodule

/* hdl/fafw_front.sv */
// ----------------------------------------------------------------------------
// fafw_front
// Accepts request transactions, classifies them (access kind, byte select
// folded into the line, block range check) and queues them for the back end.
// ----------------------------------------------------------------------------
module fafw_front #(
  parameter int unsigned MEMORY_BLOCKS  = 32,
  parameter int unsigned BYTES_PER_LINE = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  fafw_in_if.sink                req_i,
  input  fafw_pkg::back_ctl_t    ctl_i,
  output fafw_pkg::queue_out_t   head_o
);

  localparam int unsigned PtrW = $clog2(fafw_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(fafw_pkg::QUEUE_DEPTH + 1);

  fafw_pkg::req_t                  q_mem_q [fafw_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]                 wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                 cnt_q;
  logic [fafw_pkg::SEL_W-1:0]      sel_norm;
  fafw_pkg::req_t                  req_new;
  logic                            push, pop;

  always_comb begin
    if (BYTES_PER_LINE == 1) begin
      sel_norm = '0;
    end else if (32'(req_i.word_select) < BYTES_PER_LINE) begin
      sel_norm = req_i.word_select;
    end else begin
      sel_norm = fafw_pkg::SEL_W'(32'(req_i.word_select) - BYTES_PER_LINE);
    end
  end

  always_comb begin
    req_new.func     = fafw_pkg::func_e'(req_i.func);
    req_new.blk      = req_i.block_address;
    req_new.sel      = sel_norm;
    req_new.in_range = 32'(req_i.block_address) < MEMORY_BLOCKS;
    req_new.value    = req_i.write_value;
  end

  assign req_i.ready  = (cnt_q != CntW'(fafw_pkg::QUEUE_DEPTH)) && !ctl_i.clearing;
  assign push         = req_i.valid && req_i.ready;
  assign head_o.valid = cnt_q != '0;
  assign head_o.req   = q_mem_q[rd_ptr_q];
  assign pop          = ctl_i.pop && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= req_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(fafw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(fafw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

/* hdl/fafw_back.sv */
// ----------------------------------------------------------------------------
// fafw_back
// Carries out queued accesses: tag lookup over all lines, line fill from main
// memory, byte write with write-through, FIFO pointer, hit/miss counters and
// the response register. Clears main memory to its start contents after reset.
// ----------------------------------------------------------------------------
module fafw_back #(
  parameter int unsigned CACHE_LINES    = 8,
  parameter int unsigned MEMORY_BLOCKS  = 32,
  parameter int unsigned BYTES_PER_LINE = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fafw_pkg::queue_out_t   head_i,
  output fafw_pkg::back_ctl_t    ctl_o,
  fafw_out_if.source             rsp_o
);

  localparam int unsigned LineW = $clog2(CACHE_LINES);
  localparam int unsigned TagW  = (LineW > fafw_pkg::BLK_W) ? LineW : fafw_pkg::BLK_W;
  localparam int unsigned MemAw = $clog2(MEMORY_BLOCKS);
  localparam int unsigned SelW  = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
  localparam int unsigned BW    = fafw_pkg::BYTE_W;
  localparam int unsigned MemW  = BYTES_PER_LINE * BW + 1;
  localparam int unsigned CW    = fafw_pkg::COUNT_W;

  fafw_pkg::back_state_e state_q, state_d;

  // main memory, mark in the top bit
  logic [MemW-1:0]  mem_q [MEMORY_BLOCKS];
  logic [MemW-1:0]  mem_rdata_q;
  logic             mem_we, mem_re;
  logic [MemAw-1:0] mem_wa, mem_ra;
  logic [MemW-1:0]  mem_wd;
  logic [MemAw-1:0] clr_cnt_q;

  logic [TagW-1:0]  line_tags_q  [CACHE_LINES];
  logic             line_marks_q [CACHE_LINES];
  logic [BW-1:0]    line_bytes_q [CACHE_LINES][BYTES_PER_LINE];
  logic [LineW-1:0] ptr_q;

  logic [CW-1:0]    rd_hit_cnt_q, rd_miss_cnt_q, wr_hit_cnt_q, wr_miss_cnt_q;
  logic [CW-1:0]    rd_hit_cnt_d, rd_miss_cnt_d, wr_hit_cnt_d, wr_miss_cnt_d;

  fafw_pkg::req_t   cur_q;
  logic             hit_q;
  logic [LineW-1:0] line_q;

  logic             match_hit;
  logic [LineW-1:0] match_line;

  logic             fire, is_write, valid_line, line_we, wt_en;
  logic [LineW-1:0] tgt_line;
  logic [TagW-1:0]  new_tag;
  logic             new_mark;
  logic [BW-1:0]    new_bytes [BYTES_PER_LINE];
  logic [SelW-1:0]  sel_idx;

  logic             out_valid_q;
  logic             out_hit_q, out_mark_q;
  logic [2:0]       out_line_q;
  logic [4:0]       out_tag_q;
  logic [7:0]       out_data_q;
  logic [CW-1:0]    out_rh_q, out_rm_q, out_wh_q, out_wm_q;

  // lookup, lowest matching line wins
  always_comb begin
    match_hit  = 1'b0;
    match_line = '0;
    for (int j = CACHE_LINES - 1; j >= 0; j--) begin
      if (line_tags_q[j] == TagW'(head_i.req.blk)) begin
        match_hit  = 1'b1;
        match_line = LineW'(j);
      end
    end
  end

  // update datapath
  assign fire       = (state_q == fafw_pkg::ST_UPDATE) && (!out_valid_q || rsp_o.ready);
  assign is_write   = cur_q.func == fafw_pkg::FUNC_WRITE;
  assign valid_line = hit_q || cur_q.in_range;
  assign tgt_line   = hit_q ? line_q : ptr_q;
  assign sel_idx    = SelW'(cur_q.sel);

  always_comb begin
    if (hit_q) begin
      new_tag  = line_tags_q[line_q];
      new_mark = line_marks_q[line_q];
      for (int i = 0; i < BYTES_PER_LINE; i++) begin
        new_bytes[i] = line_bytes_q[line_q][i];
      end
    end else begin
      new_tag  = TagW'(cur_q.blk);
      new_mark = mem_rdata_q[MemW-1];
      for (int i = 0; i < BYTES_PER_LINE; i++) begin
        new_bytes[i] = mem_rdata_q[i*BW +: BW];
      end
    end
    if (is_write) begin
      new_mark          = 1'b1;
      new_bytes[sel_idx] = cur_q.value;
    end
  end

  assign line_we = fire && valid_line;
  assign wt_en   = fire && valid_line && is_write && (32'(new_tag) < MEMORY_BLOCKS);

  always_comb begin
    rd_hit_cnt_d  = rd_hit_cnt_q;
    rd_miss_cnt_d = rd_miss_cnt_q;
    wr_hit_cnt_d  = wr_hit_cnt_q;
    wr_miss_cnt_d = wr_miss_cnt_q;
    case ({is_write, hit_q})
      2'b01:   rd_hit_cnt_d  = fafw_pkg::sat_inc(rd_hit_cnt_q);
      2'b00:   rd_miss_cnt_d = fafw_pkg::sat_inc(rd_miss_cnt_q);
      2'b11:   wr_hit_cnt_d  = fafw_pkg::sat_inc(wr_hit_cnt_q);
      default: wr_miss_cnt_d = fafw_pkg::sat_inc(wr_miss_cnt_q);
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fafw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctl_o.pop      = 1'b0;
    ctl_o.clearing = state_q == fafw_pkg::ST_CLEAR;
    mem_we         = 1'b0;
    mem_wa         = clr_cnt_q;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = MemAw'(head_i.req.blk);
    unique case (state_q)
      fafw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        for (int i = 0; i < BYTES_PER_LINE; i++) begin
          mem_wd[i*BW +: BW] = BW'(32'(clr_cnt_q) * BYTES_PER_LINE + i);
        end
        if (clr_cnt_q == MemAw'(MEMORY_BLOCKS - 1)) begin
          state_d = fafw_pkg::ST_LOOKUP;
        end
      end
      fafw_pkg::ST_LOOKUP: begin
        if (head_i.valid) begin
          ctl_o.pop = 1'b1;
          mem_re    = head_i.req.in_range;
          state_d   = fafw_pkg::ST_UPDATE;
        end
      end
      fafw_pkg::ST_UPDATE: begin
        if (fire) begin
          mem_we  = wt_en;
          mem_wa  = MemAw'(new_tag);
          mem_wd[MemW-1] = new_mark;
          for (int i = 0; i < BYTES_PER_LINE; i++) begin
            mem_wd[i*BW +: BW] = new_bytes[i];
          end
          state_d = fafw_pkg::ST_LOOKUP;
        end
      end
      default: state_d = fafw_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (state_q == fafw_pkg::ST_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // lookup result and request hold
  always_ff @(posedge clk_i) begin
    if (ctl_o.pop) begin
      cur_q  <= head_i.req;
      hit_q  <= match_hit;
      line_q <= match_line;
    end
  end

  // line state, pointer, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CACHE_LINES; j++) begin
        line_tags_q[j]  <= TagW'(j);
        line_marks_q[j] <= 1'b0;
        for (int i = 0; i < BYTES_PER_LINE; i++) begin
          line_bytes_q[j][i] <= BW'(j * BYTES_PER_LINE + i);
        end
      end
      ptr_q         <= '0;
      rd_hit_cnt_q  <= '0;
      rd_miss_cnt_q <= '0;
      wr_hit_cnt_q  <= '0;
      wr_miss_cnt_q <= '0;
    end else begin
      if (line_we) begin
        line_tags_q[tgt_line]  <= new_tag;
        line_marks_q[tgt_line] <= new_mark;
        for (int i = 0; i < BYTES_PER_LINE; i++) begin
          line_bytes_q[tgt_line][i] <= new_bytes[i];
        end
      end
      if (fire && !hit_q && cur_q.in_range) begin
        ptr_q <= (ptr_q == LineW'(CACHE_LINES - 1)) ? '0 : ptr_q + 1'b1;
      end
      if (fire) begin
        rd_hit_cnt_q  <= rd_hit_cnt_d;
        rd_miss_cnt_q <= rd_miss_cnt_d;
        wr_hit_cnt_q  <= wr_hit_cnt_d;
        wr_miss_cnt_q <= wr_miss_cnt_d;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q  <= hit_q;
      out_line_q <= 3'(tgt_line);
      out_mark_q <= valid_line ? new_mark : 1'b0;
      out_tag_q  <= valid_line ? 5'(new_tag) : 5'd0;
      out_data_q <= valid_line ? new_bytes[sel_idx] : 8'd0;
      out_rh_q   <= rd_hit_cnt_d;
      out_rm_q   <= rd_miss_cnt_d;
      out_wh_q   <= wr_hit_cnt_d;
      out_wm_q   <= wr_miss_cnt_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.line_index   = out_line_q;
  assign rsp_o.line_mark    = out_mark_q;
  assign rsp_o.line_tag     = out_tag_q;
  assign rsp_o.data         = out_data_q;
  assign rsp_o.read_hits    = out_rh_q;
  assign rsp_o.read_misses  = out_rm_q;
  assign rsp_o.write_hits   = out_wh_q;
  assign rsp_o.write_misses = out_wm_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("main memory read and write in the same cycle");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < CACHE_LINES)
    else $error("replacement pointer out of range");

  a_hit_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fafw_pkg::ST_UPDATE && hit_q) |->
      line_tags_q[line_q] == TagW'(cur_q.blk))
    else $error("hit line does not hold the requested tag");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fafw_pkg::ST_CLEAR) |-> (!out_valid_q && !ctl_o.pop))
    else $error("transaction activity during memory clear");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (rd_hit_cnt_q >= $past(rd_hit_cnt_q) &&
              wr_miss_cnt_q >= $past(wr_miss_cnt_q)))
    else $error("hit/miss counter went backwards");

endmodule

/* dv/tb_fully_assoc_cache_fifo_write_through.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fully_assoc_cache_fifo_write_through
// Self-checking bench for the fully associative write-through cache. A model
// of the tags, marks, line bytes, main memory, FIFO pointer and counters
// predicts each response when its request transaction is accepted. Responses
// are checked in order. Directed accesses cover hits, misses, pointer wrap
// and reloading a written block. Random traffic runs with sender and receiver
// stalls, then once with neither.
// ----------------------------------------------------------------------------
module tb_fully_assoc_cache_fifo_write_through;

  localparam int unsigned CACHE_LINES    = 8;
  localparam int unsigned MEM_BLOCKS     = 32;
  localparam int unsigned LINE_BYTES     = 4;
  localparam int unsigned CYCLE_LIMIT    = 200_000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PER_RUN = 450;

  localparam int unsigned BLK_W      = fafw_pkg::BLK_W;
  localparam int unsigned SEL_W      = fafw_pkg::SEL_W;
  localparam int unsigned BYTE_W     = fafw_pkg::BYTE_W;
  localparam int unsigned COUNT_W    = fafw_pkg::COUNT_W;
  localparam int unsigned LINE_OUT_W = fafw_pkg::LINE_OUT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = fafw_pkg::COUNT_MAX;

  typedef struct packed {
    logic                  hit;
    logic [LINE_OUT_W-1:0] line_index;
    logic                  line_mark;
    logic [BLK_W-1:0]      line_tag;
    logic [BYTE_W-1:0]     data;
    logic [COUNT_W-1:0]    read_hits;
    logic [COUNT_W-1:0]    read_misses;
    logic [COUNT_W-1:0]    write_hits;
    logic [COUNT_W-1:0]    write_misses;
  } access_rsp_t;

  class cache_tracker;
    logic [BYTE_W-1:0]  mem_data [MEM_BLOCKS][LINE_BYTES];
    bit                 mem_mark [MEM_BLOCKS];
    int unsigned        line_tag [CACHE_LINES];
    bit                 line_mark [CACHE_LINES];
    logic [BYTE_W-1:0]  line_data [CACHE_LINES][LINE_BYTES];
    int unsigned        fifo_ptr;
    logic [COUNT_W-1:0] rd_hit_cnt, rd_miss_cnt, wr_hit_cnt, wr_miss_cnt;
    access_rsp_t        expected_rsp [$];
    int unsigned        mismatches;

    function new();
      for (int j = 0; j < MEM_BLOCKS; j++) begin
        mem_mark[j] = 1'b0;
        for (int i = 0; i < LINE_BYTES; i++) mem_data[j][i] = BYTE_W'(j * LINE_BYTES + i);
      end
      for (int j = 0; j < CACHE_LINES; j++) begin
        line_tag[j]  = j;
        line_mark[j] = 1'b0;
        for (int i = 0; i < LINE_BYTES; i++) line_data[j][i] = BYTE_W'(j * LINE_BYTES + i);
      end
      fifo_ptr    = 0;
      rd_hit_cnt  = '0;
      rd_miss_cnt = '0;
      wr_hit_cnt  = '0;
      wr_miss_cnt = '0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return expected_rsp.size();
    endfunction

    function void note_access(fafw_pkg::func_e f, logic [BLK_W-1:0] blk,
                              logic [SEL_W-1:0] sel_in, logic [BYTE_W-1:0] val);
      access_rsp_t r;
      int unsigned sel, line, t;
      bit found, loaded;
      sel    = sel_in % LINE_BYTES;
      line   = 0;
      found  = 1'b0;
      loaded = 1'b1;
      r      = '0;
      for (int j = 0; j < CACHE_LINES; j++) begin
        if (!found && line_tag[j] == 32'(blk)) begin
          line  = j;
          found = 1'b1;
        end
      end
      if (found) begin
        if (f == fafw_pkg::FUNC_WRITE) begin
          if (wr_hit_cnt != COUNT_MAX) wr_hit_cnt++;
        end else if (rd_hit_cnt != COUNT_MAX) begin
          rd_hit_cnt++;
        end
      end else begin
        if (f == fafw_pkg::FUNC_WRITE) begin
          if (wr_miss_cnt != COUNT_MAX) wr_miss_cnt++;
        end else if (rd_miss_cnt != COUNT_MAX) begin
          rd_miss_cnt++;
        end
        line = fifo_ptr % CACHE_LINES;
        if (32'(blk) < MEM_BLOCKS) begin
          line_tag[line]  = 32'(blk);
          line_mark[line] = mem_mark[blk];
          for (int i = 0; i < LINE_BYTES; i++) line_data[line][i] = mem_data[blk][i];
          fifo_ptr = (line + 1 >= CACHE_LINES) ? 0 : line + 1;
        end else begin
          loaded = 1'b0;
        end
      end
      if (loaded && f == fafw_pkg::FUNC_WRITE) begin
        t               = line_tag[line];
        line_mark[line] = 1'b1;
        line_data[line][sel] = val;
        if (t < MEM_BLOCKS) begin
          mem_mark[t] = 1'b1;
          for (int i = 0; i < LINE_BYTES; i++) mem_data[t][i] = line_data[line][i];
        end
      end
      r.hit        = found;
      r.line_index = LINE_OUT_W'(line);
      if (loaded) begin
        r.line_mark = line_mark[line];
        r.line_tag  = BLK_W'(line_tag[line]);
        r.data      = line_data[line][sel];
      end
      r.read_hits    = rd_hit_cnt;
      r.read_misses  = rd_miss_cnt;
      r.write_hits   = wr_hit_cnt;
      r.write_misses = wr_miss_cnt;
      expected_rsp.push_back(r);
    endfunction

    function void check_response(access_rsp_t seen);
      access_rsp_t want;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response transaction with none expected", $realtime);
        return;
      end
      want = expected_rsp.pop_front();
      if (seen.hit !== want.hit || seen.line_index !== want.line_index ||
          seen.line_mark !== want.line_mark || seen.line_tag !== want.line_tag ||
          seen.data !== want.data || seen.read_hits !== want.read_hits ||
          seen.read_misses !== want.read_misses || seen.write_hits !== want.write_hits ||
          seen.write_misses !== want.write_misses) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: exp hit=%0d line=%0d mark=%0d tag=%0d data=%02h cnt=%0d/%0d/%0d/%0d",
                   $realtime, want.hit, want.line_index, want.line_mark, want.line_tag,
                   want.data, want.read_hits, want.read_misses, want.write_hits,
                   want.write_misses);
          $display("%0t: got hit=%0d line=%0d mark=%0d tag=%0d data=%02h cnt=%0d/%0d/%0d/%0d",
                   $realtime, seen.hit, seen.line_index, seen.line_mark, seen.line_tag,
                   seen.data, seen.read_hits, seen.read_misses, seen.write_hits,
                   seen.write_misses);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned tx_idle_pct = 24;
  int unsigned rx_idle_pct = 78;
  int unsigned cycles = 0;
  cache_tracker tracker;

  fafw_in_if  req_if ();
  fafw_out_if rsp_if ();

  fully_assoc_cache_fifo_write_through #(
    .CACHE_LINES   (CACHE_LINES),
    .MEMORY_BLOCKS (MEM_BLOCKS),
    .BYTES_PER_LINE(LINE_BYTES)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fully_assoc_cache_fifo_write_through");
      $finish;
    end
  end

  // response side: check on handshake, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      tracker.check_response({rsp_if.hit, rsp_if.line_index, rsp_if.line_mark,
                              rsp_if.line_tag, rsp_if.data, rsp_if.read_hits,
                              rsp_if.read_misses, rsp_if.write_hits, rsp_if.write_misses});
    rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_access(fafw_pkg::func_e f, logic [BLK_W-1:0] blk,
                             logic [SEL_W-1:0] sel, logic [BYTE_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.func          <= f;
    req_if.block_address <= blk;
    req_if.word_select   <= sel;
    req_if.write_value   <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    tracker.note_access(f, blk, sel, val);
  endtask

  task automatic wait_all_responses();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // mostly a drifting window of ten blocks so that hits and misses mix
  task automatic random_accesses(int unsigned n);
    logic [BLK_W-1:0] hot_base, blk;
    fafw_pkg::func_e f;
    hot_base = BLK_W'($urandom_range(0, MEM_BLOCKS - 1));
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(39) == 0) hot_base = BLK_W'($urandom_range(0, MEM_BLOCKS - 1));
      if ($urandom_range(99) < 65) blk = hot_base + BLK_W'($urandom_range(0, 9));
      else blk = BLK_W'($urandom_range(0, MEM_BLOCKS - 1));
      f = $urandom_range(1) ? fafw_pkg::FUNC_WRITE : fafw_pkg::FUNC_READ;
      send_access(f, blk, SEL_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  initial begin
    tracker = new();
    req_if.valid         = 1'b0;
    req_if.func          = fafw_pkg::FUNC_READ;
    req_if.block_address = '0;
    req_if.word_select   = '0;
    req_if.write_value   = '0;
    rsp_if.ready         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < LINE_BYTES; i++)
      send_access(fafw_pkg::FUNC_READ, 5'd0, SEL_W'(i), 8'h00);
    send_access(fafw_pkg::FUNC_READ, 5'd7, 2'd3, 8'hff);
    send_access(fafw_pkg::FUNC_WRITE, 5'd3, 2'd2, 8'hff);
    send_access(fafw_pkg::FUNC_READ, 5'd31, 2'd1, 8'h00);
    send_access(fafw_pkg::FUNC_WRITE, 5'd30, 2'd0, 8'h00);
    send_access(fafw_pkg::FUNC_WRITE, 5'd9, 2'd3, 8'ha5);
    for (int b = 10; b <= 15; b++) send_access(fafw_pkg::FUNC_READ, BLK_W'(b), 2'd0, 8'h00);
    // pointer wraps, then the written block 9 is evicted and reloaded
    send_access(fafw_pkg::FUNC_READ, 5'd16, 2'd1, 8'h00);
    send_access(fafw_pkg::FUNC_READ, 5'd17, 2'd2, 8'h00);
    send_access(fafw_pkg::FUNC_READ, 5'd18, 2'd3, 8'h00);
    send_access(fafw_pkg::FUNC_READ, 5'd9, 2'd3, 8'h00);
    send_access(fafw_pkg::FUNC_READ, 5'd3, 2'd2, 8'h00);
    wait_all_responses();

    random_accesses(RANDOM_PER_RUN);
    wait_all_responses();
    tx_idle_pct = 78;
    rx_idle_pct = 24;
    random_accesses(RANDOM_PER_RUN);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_accesses(RANDOM_PER_RUN);
    wait_all_responses();
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS fully_assoc_cache_fifo_write_through");
    end else begin
      $display("FAIL fully_assoc_cache_fifo_write_through");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/fafw_pkg.sv
hdl/fafw_if.sv
hdl/fafw_front.sv
hdl/fafw_back.sv
hdl/fully_assoc_cache_fifo_write_through.sv
dv/tb_fully_assoc_cache_fifo_write_through.sv
